// ----- src/dthf_pkg.sv -----
// dthf_pkg: types, character codes and small helpers for the hex-float text formatter
// used by every module of double_to_hex_float_text_top; no dependencies

package dthf_pkg;

   localparam int MAX_PRECISION = 12;
   localparam int FRAC_W        = 52;

   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_DOT   = 8'd46;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_X     = 8'd88;
   localparam logic [7:0] CH_P     = 8'd80;
   localparam logic [7:0] CH_A     = 8'd65;
   localparam logic [7:0] CH_F     = 8'd70;
   localparam logic [7:0] CH_I     = 8'd73;
   localparam logic [7:0] CH_N     = 8'd78;

   // decoded operand, after class detection and leading-bit search
   typedef struct packed {
      logic                  nan;
      logic                  inf;
      logic                  zero;
      logic                  neg_print;
      logic [FRAC_W-1:0]     frac;
      logic [5:0]            shift;
      logic signed [11:0]    expo;
      logic [3:0]            prec;
   } dec_type;

   // everything the character sequencer needs for one text
   typedef struct packed {
      logic                  nan;
      logic                  special;
      logic                  neg_print;
      logic [1:0]            lead;
      logic                  has_frac;
      logic [FRAC_W-1:0]     digits;
      logic [3:0]            ndig;
      logic                  eneg;
      logic [15:0]           edig;
      logic [2:0]            ecount;
   } desc_type;

   typedef enum logic [9:0] {
      PH_SGN  = 10'b00_0000_0001,
      PH_SPC  = 10'b00_0000_0010,
      PH_ZRO  = 10'b00_0000_0100,
      PH_XCH  = 10'b00_0000_1000,
      PH_LEAD = 10'b00_0001_0000,
      PH_DOT  = 10'b00_0010_0000,
      PH_DIG  = 10'b00_0100_0000,
      PH_PCH  = 10'b00_1000_0000,
      PH_ESG  = 10'b01_0000_0000,
      PH_EDG  = 10'b10_0000_0000
   } phase_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] w;
      w = {4'b0000, d};
      return (d < 4'd10) ? (w + CH_ZERO) : (w + 8'd55);
   endfunction

   // letters of INF and NAN
   function automatic logic [7:0] special_char(input logic nan, input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = nan ? CH_N : CH_I;
         2'd1:    c = nan ? CH_A : CH_N;
         default: c = nan ? CH_N : CH_F;
      endcase
      return c;
   endfunction

endpackage

// ----- src/dthf_decode.sv -----
// dthf_decode: first stage; splits the double, finds the leading one of a subnormal
// and registers the decoded operand; depends on dthf_pkg

module dthf_decode import dthf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [63:0] in_bits,
   input  logic [3:0]  in_prec,
   output logic        out_valid,
   input  logic        out_ready,
   output dec_type     out_dec
);

   logic          valid_ff;
   dec_type       dec_ff;
   dec_type       dec_in;
   logic [10:0]   biased;
   logic [51:0]   frac;
   logic [5:0]    top;
   logic          sub;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

   always_comb begin
      biased = in_bits[62:52];
      frac   = in_bits[51:0];
      sub    = (biased == '0);
      top    = '0;
      for (int i = 0; i < FRAC_W; i++) begin
         if (frac[i]) begin
            top = 6'(i);
         end
      end
      dec_in.nan       = (biased == '1) && (frac != '0);
      dec_in.inf       = (biased == '1) && (frac == '0);
      dec_in.zero      = sub && (frac == '0);
      dec_in.neg_print = in_bits[63] && !dec_in.nan && !dec_in.zero;
      dec_in.frac      = frac;
      if (dec_in.zero) begin
         dec_in.shift = '0;
         dec_in.expo  = '0;
      end else if (sub) begin
         dec_in.shift = 6'd52 - top;
         dec_in.expo  = 12'({6'b0, top}) - 12'd1074;
      end else begin
         dec_in.shift = '0;
         dec_in.expo  = 12'({1'b0, biased}) - 12'd1023;
      end
      dec_in.prec = (in_prec > 4'(MAX_PRECISION)) ? 4'(MAX_PRECISION) : in_prec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         dec_ff <= dec_in;
      end
   end

endmodule

// ----- src/dthf_round.sv -----
// dthf_round: second stage; normalizes the fraction, rounds to the printed digits
// and splits the exponent into decimal digits; depends on dthf_pkg

module dthf_round import dthf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  dec_type  in_dec,
   output logic     out_valid,
   input  logic     out_ready,
   output desc_type out_desc
);

   logic          valid_ff;
   desc_type      desc_ff;
   desc_type      desc_in;
   logic [51:0]   nf;
   logic [3:0]    nd;
   logic [5:0]    lsb;
   logic          rnd;
   logic [52:0]   unit;
   logic [52:0]   masked;
   logic [52:0]   sum;
   logic          eneg;
   logic [10:0]   mag;
   logic          th;
   logic [9:0]    r1;
   logic [3:0]    hun;
   logic [6:0]    r2;
   logic [3:0]    ten;
   logic [3:0]    one;
   logic [2:0]    ecount;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_desc  = desc_ff;

   always_comb begin
      nf     = in_dec.frac << in_dec.shift;
      nd     = in_dec.prec + 4'd1;
      lsb    = 6'd52 - {nd, 2'b00};
      rnd    = (lsb != '0) && nf[lsb - 6'd1];
      unit   = 53'd1 << lsb;
      masked = {1'b0, nf} & ~(unit - 53'd1);
      sum    = masked + (rnd ? unit : 53'd0);

      eneg = in_dec.expo[11];
      mag  = eneg ? 11'(-in_dec.expo) : 11'(in_dec.expo);
      th   = (mag >= 11'd1000);
      r1   = 10'(mag - (th ? 11'd1000 : 11'd0));
      hun  = '0;
      for (int k = 1; k < 10; k++) begin
         if (r1 >= 10'(k * 100)) begin
            hun = 4'(k);
         end
      end
      r2  = 7'(r1 - 10'(hun) * 10'd100);
      ten = '0;
      for (int k = 1; k < 10; k++) begin
         if (r2 >= 7'(k * 10)) begin
            ten = 4'(k);
         end
      end
      one = 4'(r2 - 7'(ten) * 7'd10);
      if (th) begin
         ecount = 3'd4;
      end else if (hun != '0) begin
         ecount = 3'd3;
      end else if (ten != '0) begin
         ecount = 3'd2;
      end else begin
         ecount = 3'd1;
      end

      desc_in.nan       = in_dec.nan;
      desc_in.special   = in_dec.nan || in_dec.inf;
      desc_in.neg_print = in_dec.neg_print;
      desc_in.lead      = in_dec.zero ? 2'd0 : (sum[52] ? 2'd2 : 2'd1);
      desc_in.has_frac  = !in_dec.zero;
      desc_in.digits    = sum[51:0];
      desc_in.ndig      = nd;
      desc_in.eneg      = eneg;
      desc_in.edig      = {3'b000, th, hun, ten, one} << {3'd4 - ecount, 2'b00};
      desc_in.ecount    = ecount;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         desc_ff <= desc_in;
      end
   end

endmodule

// ----- src/dthf_emit.sv -----
// dthf_emit: character sequencer; walks one text descriptor and drives the
// registered one-character output; depends on dthf_pkg

module dthf_emit import dthf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  desc_type   in_desc,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_char,
   output logic       out_last
);

   logic        busy_ff;
   desc_type    desc_ff;
   phase_type   phase_ff;
   phase_type   phase_in;
   phase_type   start_phase;
   logic [3:0]  cnt_ff;
   logic [3:0]  cnt_in;
   logic [51:0] dig_ff;
   logic [51:0] dig_in;
   logic [15:0] edig_ff;
   logic [15:0] edig_in;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_char_ff;
   logic        rsp_last_ff;
   logic [7:0]  char_c;
   logic        final_c;
   logic        go;

   assign go        = busy_ff && (!rsp_valid_ff || out_ready);
   assign in_ready  = !busy_ff || (go && final_c);
   assign out_valid = rsp_valid_ff;
   assign out_char  = rsp_char_ff;
   assign out_last  = rsp_last_ff;

   always_comb begin
      if (in_desc.neg_print) begin
         start_phase = PH_SGN;
      end else if (in_desc.special) begin
         start_phase = PH_SPC;
      end else begin
         start_phase = PH_ZRO;
      end
   end

   always_comb begin
      char_c   = CH_ZERO;
      final_c  = 1'b0;
      phase_in = phase_ff;
      cnt_in   = '0;
      dig_in   = dig_ff;
      edig_in  = edig_ff;
      case (phase_ff)
         PH_SGN: begin
            char_c   = CH_MINUS;
            phase_in = desc_ff.special ? PH_SPC : PH_ZRO;
         end
         PH_SPC: begin
            char_c  = special_char(desc_ff.nan, cnt_ff[1:0]);
            final_c = (cnt_ff == 4'd2);
            cnt_in  = cnt_ff + 4'd1;
         end
         PH_ZRO: begin
            char_c   = CH_ZERO;
            phase_in = PH_XCH;
         end
         PH_XCH: begin
            char_c   = CH_X;
            phase_in = PH_LEAD;
         end
         PH_LEAD: begin
            char_c   = hex_char({2'b00, desc_ff.lead});
            phase_in = desc_ff.has_frac ? PH_DOT : PH_PCH;
         end
         PH_DOT: begin
            char_c   = CH_DOT;
            phase_in = PH_DIG;
         end
         PH_DIG: begin
            char_c = hex_char(dig_ff[51:48]);
            dig_in = {dig_ff[47:0], 4'b0000};
            if (cnt_ff == desc_ff.ndig - 4'd1) begin
               phase_in = PH_PCH;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         PH_PCH: begin
            char_c   = CH_P;
            phase_in = PH_ESG;
         end
         PH_ESG: begin
            char_c   = desc_ff.eneg ? CH_MINUS : CH_PLUS;
            phase_in = PH_EDG;
         end
         PH_EDG: begin
            char_c  = hex_char(edig_ff[15:12]);
            edig_in = {edig_ff[11:0], 4'b0000};
            final_c = (cnt_ff == {1'b0, desc_ff.ecount - 3'd1});
            cnt_in  = cnt_ff + 4'd1;
         end
         default: begin
            char_c   = CH_ZERO;
            phase_in = PH_ZRO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_ZRO;
         cnt_ff   <= '0;
      end else if (in_valid && in_ready) begin
         busy_ff  <= 1'b1;
         phase_ff <= start_phase;
         cnt_ff   <= '0;
      end else if (go) begin
         busy_ff  <= !final_c;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         desc_ff <= in_desc;
         dig_ff  <= in_desc.digits;
         edig_ff <= in_desc.edig;
      end else if (go) begin
         dig_ff  <= dig_in;
         edig_ff <= edig_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_char_ff <= char_c;
         rsp_last_ff <= final_c;
      end
   end

endmodule

// ----- src/double_to_hex_float_text_top.sv -----
// double_to_hex_float_text_top: upper-case hex-float text formatter for IEEE doubles
// depends on dthf_pkg, dthf_decode, dthf_round and dthf_emit
//
// Usage:
//   req channel: one word is a raw double (req_value_bits) and a precision
//   (req_precision, values above 12 act as 12); precision+1 fraction digits print.
//   rsp channel: the text, one ASCII character per word, rsp_last on the final one.
//   Special texts: zero gives 0X0P+0, infinity INF or -INF, NaN gives NAN.
// Path: a req word goes through the decode register, the rounding register and the
//   character sequencer into the output register.
// Throughput: one character per cycle while rsp_ready is high; texts have 3 to 24
//   characters. The character sequencer is the limit: it walks one text at a time
//   while the two stages ahead of it already hold the next words.
// Reset: synchronous, active high; all valid flags clear, no text is in flight.
// Stall: while rsp_ready is low the output register holds its word, the
//   sequencer pauses and req_ready drops once both front stages are full.

module double_to_hex_float_text_top import dthf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value_bits,
   input  logic [3:0]  req_precision,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);

   logic     dec_valid;
   logic     dec_ready;
   dec_type  dec;
   logic     desc_valid;
   logic     desc_ready;
   desc_type desc;

   dthf_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_bits   (req_value_bits),
      .in_prec   (req_precision),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_dec   (dec)
   );

   dthf_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_dec    (dec),
      .out_valid (desc_valid),
      .out_ready (desc_ready),
      .out_desc  (desc)
   );

   dthf_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (desc_valid),
      .in_ready  (desc_ready),
      .in_desc   (desc),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_char  (rsp_out_char),
      .out_last  (rsp_last)
   );

endmodule

// ----- src/dthf_checker.sv -----
// dthf_checker: port-level assertions on the text output of the formatter
// bound to double_to_hex_float_text_top; depends on dthf_pkg

module dthf_checker import dthf_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last
);

   // high when the next word shown opens a new text
   logic start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         start_ff <= rsp_last;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_last_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         (rsp_out_char >= CH_ZERO && rsp_out_char <= 8'd57) ||
         rsp_out_char == CH_F || rsp_out_char == CH_N)
      else $error("text ends in an unexpected character");

   a_first_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start_ff |->
         rsp_out_char == CH_MINUS || rsp_out_char == CH_ZERO ||
         rsp_out_char == CH_I || rsp_out_char == CH_N)
      else $error("text starts with an unexpected character");

   a_dot_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_char == CH_DOT |-> !rsp_last)
      else $error("text ends at the radix point");

endmodule

bind double_to_hex_float_text_top dthf_checker u_dthf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_char (rsp_out_char),
   .rsp_last     (rsp_last)
);
